@@ rtl/vcc_pkg.sv @@
// ----------------------------------------------------------------------------
// vcc_pkg
// Shared types, codes and helpers for the vending credit and change block.
// ----------------------------------------------------------------------------
package vcc_pkg;

    localparam int DEF_ITEM_SLOTS = 16;
    localparam int CREDIT_W       = 10;
    localparam int COUNT_W        = 8;
    localparam int COIN_TYPES     = 3;

    localparam logic [CREDIT_W-1:0] CREDIT_MAX = '1;
    localparam logic [COUNT_W-1:0]  COUNT_MAX  = '1;

    // x / 5 == (x * 205) >> 10 for every 10-bit x
    localparam logic [7:0] DIV5_MUL   = 8'd205;
    localparam int         DIV5_SHIFT = 10;

    localparam logic [2:0] KIND_COIN      = 3'd0;
    localparam logic [2:0] KIND_SELECT    = 3'd1;
    localparam logic [2:0] KIND_CHANGE    = 3'd2;
    localparam logic [2:0] KIND_LOAD_ITEM = 3'd3;
    localparam logic [2:0] KIND_LOAD_COIN = 3'd4;

    localparam logic [1:0] COIN_QUARTER = 2'd0;
    localparam logic [1:0] COIN_DIME    = 2'd1;
    localparam logic [1:0] COIN_NICKEL  = 2'd2;

    localparam logic [2:0] ST_COIN      = 3'd0;
    localparam logic [2:0] ST_DISPENSED = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_NO_CREDIT = 3'd4;
    localparam logic [2:0] ST_NO_CHANGE = 3'd5;
    localparam logic [2:0] ST_PAID      = 3'd6;
    localparam logic [2:0] ST_LOADED    = 3'd7;

    typedef struct packed {
        logic [COUNT_W-1:0] stock;
        logic [COUNT_W-1:0] price;
    } item_entry_t;

    typedef struct packed {
        logic               ok;
        logic [COUNT_W-1:0] quarters;
        logic [COUNT_W-1:0] dimes;
        logic [COUNT_W-1:0] nickels;
    } change_t;

    // Map the unused coin code onto the nickel.
    function automatic logic [1:0] coin_slot(input logic [1:0] raw);
        logic [1:0] slot;
        slot = (raw == COIN_QUARTER || raw == COIN_DIME) ? raw : COIN_NICKEL;
        return slot;
    endfunction

    function automatic logic [2:0] coin_value(input logic [1:0] slot);
        logic [2:0] value;
        case (slot)
            COIN_QUARTER: value = 3'd5;
            COIN_DIME:    value = 3'd2;
            default:      value = 3'd1;
        endcase
        return value;
    endfunction

endpackage

@@ rtl/vending_credit_and_change.sv @@
// ----------------------------------------------------------------------------
// vending_credit_and_change
// Vending controller: credit, coin stock and item slots, one result per event.
//
//  channel | dir | tdata                                   | tuser
//  s_      | in  | coin_type, item_index, stock_value,     | kind
//          |     | price_nickels                           |
//  m_      | out | quarters_out, dimes_out, nickels_out,   | status
//          |     | credit_now                              |
//
// Each transaction reads the item memory when the event is taken in S_IDLE,
// then updates state and loads the output register in S_EXEC.
// An event is taken while the output register still holds a result; the
// update cycle waits until that result is taken.
// Reset clears credit, coin stock and all slot valid bits at once.
// ----------------------------------------------------------------------------
module vending_credit_and_change
    import vcc_pkg::*;
#(
    parameter int ITEM_SLOTS = DEF_ITEM_SLOTS
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // coin_type, item_index, stock_value, price_nickels
    input  logic [2:0]  s_tuser,   // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // quarters_out, dimes_out, nickels_out, credit_now
    output logic [2:0]  m_tuser    // status
);

    localparam int ADDR_W = (ITEM_SLOTS > 1) ? $clog2(ITEM_SLOTS) : 1;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              state_reg, state_next;
    logic [2:0]          kind_reg;
    logic [1:0]          ct_reg;
    logic                slot_ok_reg;
    logic [ADDR_W-1:0]   addr_reg;
    logic [COUNT_W-1:0]  sval_reg;
    logic [COUNT_W-1:0]  pval_reg;
    logic [COUNT_W-1:0]  quot_reg;
    logic [CREDIT_W-1:0] credit_reg, credit_next;
    logic [COUNT_W-1:0]  coin_reg [COIN_TYPES];
    logic [COUNT_W-1:0]  coin_next [COIN_TYPES];

    logic                out_valid_reg;
    logic [2:0]          status_reg, status_next;
    logic [COUNT_W-1:0]  q_out_reg, q_out_next;
    logic [COUNT_W-1:0]  d_out_reg, d_out_next;
    logic [COUNT_W-1:0]  n_out_reg, n_out_next;

    logic                accept;
    logic                fire;
    logic [8:0]          idx_ext;
    logic [ADDR_W-1:0]   in_addr;
    logic                in_slot_ok;
    logic [17:0]         quot_prod;
    item_entry_t         rd_entry;
    item_entry_t         entry;
    item_entry_t         wr_entry;
    logic                wr_en;
    logic [CREDIT_W:0]   credit_sum;
    change_t             change;

    assign idx_ext    = {5'b0, s_tdata[5:2]};
    assign in_addr    = idx_ext[ADDR_W-1:0];
    assign in_slot_ok = (idx_ext < 9'(ITEM_SLOTS));
    assign quot_prod  = {8'b0, credit_reg} * {10'b0, DIV5_MUL};

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign fire     = (state_reg == S_EXEC) && (!out_valid_reg || m_tready);

    vcc_item_mem #(
        .ITEM_SLOTS (ITEM_SLOTS),
        .ADDR_W     (ADDR_W)
    ) u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_addr),
        .rd_data (rd_entry),
        .wr_en   (wr_en),
        .wr_addr (addr_reg),
        .wr_data (wr_entry)
    );

    vcc_change u_change (
        .credit  (credit_reg),
        .quot5   (quot_reg),
        .stock_q (coin_reg[COIN_QUARTER]),
        .stock_d (coin_reg[COIN_DIME]),
        .stock_n (coin_reg[COIN_NICKEL]),
        .change  (change)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (accept) state_next = S_EXEC;
            S_EXEC:  if (fire) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        entry       = slot_ok_reg ? rd_entry : '0;
        credit_sum  = {1'b0, credit_reg} + {8'b0, coin_value(ct_reg)};
        credit_next = credit_reg;
        coin_next   = coin_reg;
        status_next = ST_LOADED;
        q_out_next  = '0;
        d_out_next  = '0;
        n_out_next  = '0;
        wr_en       = 1'b0;
        wr_entry    = entry;

        case (kind_reg)
            KIND_COIN:
            begin
                credit_next = credit_sum[CREDIT_W] ? CREDIT_MAX
                                                   : credit_sum[CREDIT_W-1:0];
                if (coin_reg[ct_reg] != COUNT_MAX)
                begin
                    coin_next[ct_reg] = coin_reg[ct_reg] + 8'd1;
                end
                status_next = ST_COIN;
            end
            KIND_SELECT:
            begin
                if (entry.stock != '0 && credit_reg >= {2'b00, entry.price})
                begin
                    credit_next    = credit_reg - {2'b00, entry.price};
                    wr_en          = 1'b1;
                    wr_entry.stock = entry.stock - 8'd1;
                    status_next    = ST_DISPENSED;
                end
                else if (credit_reg < {2'b00, entry.price})
                begin
                    status_next = ST_SHORT;
                end
                else
                begin
                    status_next = ST_EMPTY;
                end
            end
            KIND_CHANGE:
            begin
                if (credit_reg == '0)
                begin
                    status_next = ST_NO_CREDIT;
                end
                else if (change.ok)
                begin
                    coin_next[COIN_QUARTER] = coin_reg[COIN_QUARTER] - change.quarters;
                    coin_next[COIN_DIME]    = coin_reg[COIN_DIME] - change.dimes;
                    coin_next[COIN_NICKEL]  = coin_reg[COIN_NICKEL] - change.nickels;
                    credit_next = '0;
                    q_out_next  = change.quarters;
                    d_out_next  = change.dimes;
                    n_out_next  = change.nickels;
                    status_next = ST_PAID;
                end
                else
                begin
                    status_next = ST_NO_CHANGE;
                end
            end
            KIND_LOAD_ITEM:
            begin
                wr_en          = slot_ok_reg;
                wr_entry.stock = sval_reg;
                wr_entry.price = pval_reg;
            end
            KIND_LOAD_COIN:
            begin
                coin_next[ct_reg] = sval_reg;
            end
            default:
            begin
                status_next = ST_LOADED;
            end
        endcase

        if (!fire)
        begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            credit_reg    <= '0;
            coin_reg      <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (fire)
            begin
                credit_reg    <= credit_next;
                coin_reg      <= coin_next;
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= s_tuser;
            ct_reg      <= coin_slot(s_tdata[1:0]);
            slot_ok_reg <= in_slot_ok;
            addr_reg    <= in_addr;
            sval_reg    <= s_tdata[13:6];
            pval_reg    <= s_tdata[21:14];
            quot_reg    <= quot_prod[DIV5_SHIFT+COUNT_W-1:DIV5_SHIFT];
        end
        if (fire)
        begin
            status_reg <= status_next;
            q_out_reg  <= q_out_next;
            d_out_reg  <= d_out_next;
            n_out_reg  <= n_out_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = status_reg;
    assign m_tdata  = {6'b0, credit_reg, n_out_reg, d_out_reg, q_out_reg};

endmodule

@@ rtl/vcc_item_mem.sv @@
// ----------------------------------------------------------------------------
// vcc_item_mem
// Item slot memory (stock and price) with a registered read and a
// valid bit per slot so unwritten slots read as empty with price zero.
// ----------------------------------------------------------------------------
module vcc_item_mem
    import vcc_pkg::*;
#(
    parameter int ITEM_SLOTS = DEF_ITEM_SLOTS,
    parameter int ADDR_W     = 4
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output item_entry_t       rd_data,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  item_entry_t       wr_data
);

    item_entry_t             mem [ITEM_SLOTS];
    logic [ITEM_SLOTS-1:0]   valid_reg;
    item_entry_t             rd_data_reg;
    logic                    rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                valid_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_valid_reg <= valid_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_valid_reg ? rd_data_reg : '0;

endmodule

@@ rtl/vcc_change.sv @@
// ----------------------------------------------------------------------------
// vcc_change
// Greedy change split over quarters, dimes and nickels, bounded by stock.
// ----------------------------------------------------------------------------
module vcc_change
    import vcc_pkg::*;
(
    input  logic [CREDIT_W-1:0] credit,
    input  logic [COUNT_W-1:0]  quot5,
    input  logic [COUNT_W-1:0]  stock_q,
    input  logic [COUNT_W-1:0]  stock_d,
    input  logic [COUNT_W-1:0]  stock_n,
    output change_t             change
);

    logic [COUNT_W-1:0]  q;
    logic [COUNT_W-1:0]  d;
    logic [COUNT_W-1:0]  n;
    logic [CREDIT_W-1:0] five_q;
    logic [CREDIT_W-1:0] rem1;
    logic [CREDIT_W-2:0] half;
    logic [CREDIT_W-1:0] rem2;

    always_comb
    begin
        q      = (quot5 < stock_q) ? quot5 : stock_q;
        five_q = {q, 2'b00} + {2'b00, q};
        rem1   = credit - five_q;
        half   = rem1[CREDIT_W-1:1];
        d      = (half < {1'b0, stock_d}) ? half[COUNT_W-1:0] : stock_d;
        rem2   = rem1 - {1'b0, d, 1'b0};
        n      = (rem2 < {2'b00, stock_n}) ? rem2[COUNT_W-1:0] : stock_n;

        change.ok       = (rem2 == {2'b00, n});
        change.quarters = q;
        change.dimes    = d;
        change.nickels  = n;
    end

endmodule

@@ rtl/vcc_checker.sv @@
// ----------------------------------------------------------------------------
// vcc_port_checks
// Port-level checks on the result channel of the vending controller.
// ----------------------------------------------------------------------------
module vcc_port_checks
    import vcc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic [2:0]  m_tuser
);

    // Coins leave only with a paid change transaction.
    a_coins_only_paid: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser != ST_PAID) |-> (m_tdata[23:0] == 24'd0))
        else $error("coins out without paid change");

    a_paid_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_PAID) |-> (m_tdata[33:24] == 10'd0))
        else $error("credit left after paid change");

    a_no_credit_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_NO_CREDIT) |-> (m_tdata[33:24] == 10'd0))
        else $error("no-credit result with credit");

    a_coin_credit: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == ST_COIN) |-> (m_tdata[33:24] != 10'd0))
        else $error("coin taken with zero credit");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
        else $error("stalled result changed");

endmodule

bind vending_credit_and_change vcc_port_checks u_vcc_port_checks (.*);
